FILE: hw/rtl/frustum_grid_window_core_macros.svh
// Assertion macros shared by the frustum grid window RTL.
`ifndef FRUSTUM_GRID_WINDOW_CORE_MACROS_SVH
`define FRUSTUM_GRID_WINDOW_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define FGW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define FGW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fgw_pkg.sv
// Shared types, constants and helpers of the frustum grid window block.
`default_nettype none

package fgw_pkg;

   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 5;
   localparam int ADDR_LSB   = 2;
   localparam int COORD_IN_W = 32;
   localparam int INV_W      = 31;
   localparam int CELL_W     = 8;
   // signed product of a 31 bit extent and a 32 bit matrix term
   localparam int PROD_W     = 63;
   // stage registers from input capture to output register
   localparam int PIPE_DEPTH = 7;

   localparam logic [INV_W-1:0]  INV_RESET   = 31'd65536;
   localparam logic [CELL_W-1:0] CELLS_RESET = 8'd1;

   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Z   = 3'd1,
      REG_INV_CELL_X = 3'd2,
      REG_INV_CELL_Z = 3'd3,
      REG_CELLS_X    = 3'd4,
      REG_CELLS_Z    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] base_x;
      logic signed [COORD_IN_W-1:0] base_z;
      logic [INV_W-1:0]             inv_cell_x;
      logic [INV_W-1:0]             inv_cell_z;
      logic [CELL_W-1:0]            cells_x;
      logic [CELL_W-1:0]            cells_z;
   } cfg_type;

   typedef struct packed {
      logic z_outer;
      logic reverse_x;
      logic reverse_z;
   } flags_type;

   typedef struct packed {
      logic [CELL_W-1:0] min_x;
      logic [CELL_W-1:0] max_x;
      logic [CELL_W-1:0] min_z;
      logic [CELL_W-1:0] max_z;
      flags_type         flags;
   } window_type;

   // highest valid cell index; an empty grid counts as one cell
   function automatic logic [CELL_W-1:0] cell_limit(input logic [CELL_W-1:0] cells);
      return (cells == '0) ? '0 : cells - 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fgw_rotate.sv
// Far-corner rotation: products, floored shifts and corner sums over three stages.
`default_nettype none

module fgw_rotate #(
   parameter  int FRAC_BITS = 16,
   localparam int AW = fgw_pkg::PROD_W - FRAC_BITS,
   localparam int SW = AW + 1,
   localparam int CW = AW + 2
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    right_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    right_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    up_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    up_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    back_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    back_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    pos_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0]    pos_z,
   input  logic [fgw_pkg::INV_W-1:0]                far_half_width,
   input  logic [fgw_pkg::INV_W-1:0]                far_half_height,
   input  logic [fgw_pkg::INV_W-1:0]                far_distance,
   output logic signed [CW-1:0]                     coord [2][5]
);

   localparam int PW = fgw_pkg::PROD_W;
   localparam int IW = fgw_pkg::COORD_IN_W;

   // matrix terms: right x/z, up x/z, back x/z; extents: width, height, far
   logic signed [IW-1:0]                 mat [6];
   logic [fgw_pkg::INV_W-1:0]            extent [3];
   logic signed [2*IW-1:0]               prod_in [6];
   logic signed [PW-1:0]                 prod_ff [6];
   logic signed [IW-1:0]                 pos_ff [2];

   logic signed [AW-1:0]                 flo [6];
   logic signed [AW-1:0]                 neg [6];
   logic signed [SW-1:0]                 pair_in [2][4];
   logic signed [SW-1:0]                 pair_ff [2][4];
   logic signed [SW-1:0]                 base_in [2];
   logic signed [SW-1:0]                 base_ff [2];
   logic signed [IW-1:0]                 pos2_ff [2];

   logic signed [CW-1:0]                 coord_in [2][5];
   logic signed [CW-1:0]                 coord_ff [2][5];

   assign mat[0] = right_x;
   assign mat[1] = right_z;
   assign mat[2] = up_x;
   assign mat[3] = up_z;
   assign mat[4] = back_x;
   assign mat[5] = back_z;
   assign extent[0] = far_half_width;
   assign extent[1] = far_half_height;
   assign extent[2] = far_distance;

   // stage 1: six extent-by-term products
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         prod_in[i] = $signed({1'b0, extent[i >> 1]}) * mat[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i][PW-1:0];
         end
         pos_ff[0] <= pos_x;
         pos_ff[1] <= pos_z;
      end
   end

   // stage 2: floor of +P and -P after the shift, then pairwise sums
   // floor(-P / 2^F) = ~floor(P / 2^F) + (no fraction bits set)
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         flo[i] = $signed(prod_ff[i][PW-1:FRAC_BITS]);
         neg[i] = ~flo[i] + AW'(prod_ff[i][FRAC_BITS-1:0] == '0);
      end
      for (int a = 0; a < 2; a++) begin
         base_in[a] = SW'(neg[4 + a]) + SW'(pos_ff[a]);
         for (int k = 0; k < 4; k++) begin
            pair_in[a][k] = SW'(((k & 1) != 0) ? neg[a] : flo[a])
                          + SW'(((k & 2) != 0) ? neg[2 + a] : flo[2 + a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pair_ff <= pair_in;
         base_ff <= base_in;
         pos2_ff <= pos_ff;
      end
   end

   // stage 3: full world coordinates; lane 0 is the camera itself
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         coord_in[a][0] = CW'(pos2_ff[a]);
         for (int k = 0; k < 4; k++) begin
            coord_in[a][k + 1] = CW'(pair_ff[a][k]) + CW'(base_ff[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fgw_cell.sv
// Grid cell index of five points along one axis, over three stages.
`default_nettype none

module fgw_cell #(
   parameter  int FRAC_BITS = 16,
   localparam int CW = fgw_pkg::PROD_W - FRAC_BITS + 2,
   localparam int HW = CW - 32,
   localparam int FW = CW + fgw_pkg::INV_W,
   localparam int QW = FW - 2 * FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [CW-1:0]                  coord [5],
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] origin,
   input  logic [fgw_pkg::INV_W-1:0]             inv,
   input  logic [fgw_pkg::CELL_W-1:0]            cells,
   output logic [fgw_pkg::CELL_W-1:0]            idx [5]
);

   localparam int LW = 32 + fgw_pkg::INV_W;
   localparam int CLW = fgw_pkg::CELL_W;

   logic signed [CW:0]   diff [5];
   logic [CW-1:0]        dist_in [5];
   logic [CW-1:0]        dist_ff [5];
   logic [LW-1:0]        lo_in [5];
   logic [LW-1:0]        lo_ff [5];
   logic [HW+fgw_pkg::INV_W-1:0] hi_in [5];
   logic [HW+fgw_pkg::INV_W-1:0] hi_ff [5];
   logic [FW-1:0]        full [5];
   logic [QW-1:0]        quot [5];
   logic [CLW-1:0]       lim;
   logic [CLW-1:0]       idx_in [5];
   logic [CLW-1:0]       idx_ff [5];

   assign lim = fgw_pkg::cell_limit(cells);

   // stage 4: offset from the origin; on or left of it gives distance zero
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         diff[i]    = (CW + 1)'(coord[i]) - (CW + 1)'(origin);
         dist_in[i] = (diff[i] > 0) ? diff[i][CW-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   // stage 5: distance times reciprocal as two partial products
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         lo_in[i] = LW'(dist_ff[i][31:0]) * LW'(inv);
         hi_in[i] = (HW + fgw_pkg::INV_W)'(dist_ff[i][CW-1:32])
                  * (HW + fgw_pkg::INV_W)'(inv);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // stage 6: recombine, drop the fraction, saturate at the last cell
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         full[i] = {hi_ff[i], 32'b0} + FW'(lo_ff[i]);
         quot[i] = full[i][FW-1:2*FRAC_BITS];
         if ((|quot[i][QW-1:CLW]) || (quot[i][CLW-1:0] > lim)) begin
            idx_in[i] = lim;
         end else begin
            idx_in[i] = quot[i][CLW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= idx_in;
      end
   end

   assign idx = idx_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fgw_window.sv
// Bounding window of the five cells, grown by one cell, into the output register.
`default_nettype none

module fgw_window (
   input  logic                            clock,
   input  logic                            en,
   input  logic [fgw_pkg::CELL_W-1:0]      idx_x [5],
   input  logic [fgw_pkg::CELL_W-1:0]      idx_z [5],
   input  fgw_pkg::cfg_type                cfg,
   input  fgw_pkg::flags_type              flags,
   output fgw_pkg::window_type             result
);

   logic [fgw_pkg::CELL_W-1:0] lim_x;
   logic [fgw_pkg::CELL_W-1:0] lim_z;
   logic [fgw_pkg::CELL_W-1:0] mn_x;
   logic [fgw_pkg::CELL_W-1:0] mx_x;
   logic [fgw_pkg::CELL_W-1:0] mn_z;
   logic [fgw_pkg::CELL_W-1:0] mx_z;
   fgw_pkg::window_type        result_in;
   fgw_pkg::window_type        result_ff;

   assign lim_x = fgw_pkg::cell_limit(cfg.cells_x);
   assign lim_z = fgw_pkg::cell_limit(cfg.cells_z);

   // min and max over the camera cell and the four corner cells
   always_comb begin
      mn_x = idx_x[0];
      mx_x = idx_x[0];
      mn_z = idx_z[0];
      mx_z = idx_z[0];
      for (int i = 1; i < 5; i++) begin
         if (idx_x[i] < mn_x) mn_x = idx_x[i];
         if (idx_x[i] > mx_x) mx_x = idx_x[i];
         if (idx_z[i] < mn_z) mn_z = idx_z[i];
         if (idx_z[i] > mx_z) mx_z = idx_z[i];
      end
      // grow by one cell each way, staying inside the grid
      result_in.min_x = (mn_x != '0) ? mn_x - 1'b1 : mn_x;
      result_in.max_x = (mx_x < lim_x) ? mx_x + 1'b1 : mx_x;
      result_in.min_z = (mn_z != '0) ? mn_z - 1'b1 : mn_z;
      result_in.max_z = (mx_z < lim_z) ? mx_z + 1'b1 : mx_z;
      result_in.flags = flags;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/frustum_grid_window_core.sv
// Top level of the frustum grid window block: register port, control and datapath.
// The result of an item is offered on rsp_valid from the output register, the last stage register.
// Throughput: one item per cycle; seven stage registers, the rotation and cell
// multipliers each fully pipelined, and one shared stall that freezes every stage.
// Reset: synchronous; clears all valid bits and loads register defaults, no clear pass.
`default_nettype none

`include "frustum_grid_window_core_macros.svh"

module frustum_grid_window_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fgw_pkg::ADDR_W-1:0]            paddr,
   input  logic [fgw_pkg::DATA_W-1:0]            pwdata,
   output logic [fgw_pkg::DATA_W-1:0]            prdata,
   output logic                                  pready,
   // pose input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_right_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_right_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_up_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_up_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_back_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_back_z,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_pos_x,
   input  logic signed [fgw_pkg::COORD_IN_W-1:0] req_pos_z,
   input  logic [fgw_pkg::INV_W-1:0]             req_far_half_width,
   input  logic [fgw_pkg::INV_W-1:0]             req_far_half_height,
   input  logic [fgw_pkg::INV_W-1:0]             req_far_distance,
   // window output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [fgw_pkg::CELL_W-1:0]            rsp_min_cell_x,
   output logic [fgw_pkg::CELL_W-1:0]            rsp_max_cell_x,
   output logic [fgw_pkg::CELL_W-1:0]            rsp_min_cell_z,
   output logic [fgw_pkg::CELL_W-1:0]            rsp_max_cell_z,
   output logic                                  rsp_z_outer,
   output logic                                  rsp_reverse_x,
   output logic                                  rsp_reverse_z
);

   localparam int CW    = fgw_pkg::PROD_W - FRAC_BITS + 2;
   localparam int DEPTH = fgw_pkg::PIPE_DEPTH;
   localparam int IW    = fgw_pkg::COORD_IN_W;

   fgw_pkg::cfg_type            cfg_ff;
   fgw_pkg::cfg_type            cfg_in;
   fgw_pkg::reg_index_type      reg_idx;
   logic                        csr_write;

   logic                        pipe_en;
   logic [DEPTH-1:0]            vld_ff;
   logic [DEPTH-1:0]            vld_in;
   fgw_pkg::flags_type          flg_in;
   fgw_pkg::flags_type          flg_ff [DEPTH-1];
   logic [IW-1:0]               abs_bx;
   logic [IW-1:0]               abs_bz;

   logic signed [CW-1:0]        coord [2][5];
   logic [fgw_pkg::CELL_W-1:0]  idx_x [5];
   logic [fgw_pkg::CELL_W-1:0]  idx_z [5];
   fgw_pkg::window_type         result;

   // register port: writes in the access phase, reads straight from the registers
   assign pready    = 1'b1;
   assign reg_idx   = fgw_pkg::reg_index_type'(paddr[fgw_pkg::ADDR_W-1:fgw_pkg::ADDR_LSB]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            fgw_pkg::REG_ORIGIN_X:   cfg_in.base_x     = $signed(pwdata);
            fgw_pkg::REG_ORIGIN_Z:   cfg_in.base_z     = $signed(pwdata);
            fgw_pkg::REG_INV_CELL_X: cfg_in.inv_cell_x = pwdata[fgw_pkg::INV_W-1:0];
            fgw_pkg::REG_INV_CELL_Z: cfg_in.inv_cell_z = pwdata[fgw_pkg::INV_W-1:0];
            fgw_pkg::REG_CELLS_X:    cfg_in.cells_x    = pwdata[fgw_pkg::CELL_W-1:0];
            fgw_pkg::REG_CELLS_Z:    cfg_in.cells_z    = pwdata[fgw_pkg::CELL_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_x     <= '0;
         cfg_ff.base_z     <= '0;
         cfg_ff.inv_cell_x <= fgw_pkg::INV_RESET;
         cfg_ff.inv_cell_z <= fgw_pkg::INV_RESET;
         cfg_ff.cells_x    <= fgw_pkg::CELLS_RESET;
         cfg_ff.cells_z    <= fgw_pkg::CELLS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         fgw_pkg::REG_ORIGIN_X:   prdata = cfg_ff.base_x;
         fgw_pkg::REG_ORIGIN_Z:   prdata = cfg_ff.base_z;
         fgw_pkg::REG_INV_CELL_X: prdata = fgw_pkg::DATA_W'(cfg_ff.inv_cell_x);
         fgw_pkg::REG_INV_CELL_Z: prdata = fgw_pkg::DATA_W'(cfg_ff.inv_cell_z);
         fgw_pkg::REG_CELLS_X:    prdata = fgw_pkg::DATA_W'(cfg_ff.cells_x);
         fgw_pkg::REG_CELLS_Z:    prdata = fgw_pkg::DATA_W'(cfg_ff.cells_z);
         default:                 prdata = '0;
      endcase
   end

   // one stall for the whole pipe: it moves unless the output item is held
   assign pipe_en   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = pipe_en && !reset;
   assign rsp_valid = vld_ff[DEPTH-1];

   assign vld_in = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // walk-order flags, carried alongside the datapath
   assign abs_bx = req_back_x[IW-1] ? (~req_back_x + 1'b1) : req_back_x;
   assign abs_bz = req_back_z[IW-1] ? (~req_back_z + 1'b1) : req_back_z;

   always_comb begin
      flg_in.z_outer   = (abs_bz >= abs_bx);
      flg_in.reverse_x = req_back_x[IW-1] || (req_back_x == '0);
      flg_in.reverse_z = req_back_z[IW-1] || (req_back_z == '0);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         flg_ff[0] <= flg_in;
         for (int i = 1; i < DEPTH - 1; i++) begin
            flg_ff[i] <= flg_ff[i-1];
         end
      end
   end

   // datapath
   fgw_rotate #(
      .FRAC_BITS(FRAC_BITS)
   ) u_rotate (
      .clock           (clock),
      .en              (pipe_en),
      .right_x         (req_right_x),
      .right_z         (req_right_z),
      .up_x            (req_up_x),
      .up_z            (req_up_z),
      .back_x          (req_back_x),
      .back_z          (req_back_z),
      .pos_x           (req_pos_x),
      .pos_z           (req_pos_z),
      .far_half_width  (req_far_half_width),
      .far_half_height (req_far_half_height),
      .far_distance    (req_far_distance),
      .coord           (coord)
   );

   fgw_cell #(
      .FRAC_BITS(FRAC_BITS)
   ) u_cell_x (
      .clock  (clock),
      .en     (pipe_en),
      .coord  (coord[0]),
      .origin (cfg_ff.base_x),
      .inv    (cfg_ff.inv_cell_x),
      .cells  (cfg_ff.cells_x),
      .idx    (idx_x)
   );

   fgw_cell #(
      .FRAC_BITS(FRAC_BITS)
   ) u_cell_z (
      .clock  (clock),
      .en     (pipe_en),
      .coord  (coord[1]),
      .origin (cfg_ff.base_z),
      .inv    (cfg_ff.inv_cell_z),
      .cells  (cfg_ff.cells_z),
      .idx    (idx_z)
   );

   fgw_window u_window (
      .clock  (clock),
      .en     (pipe_en),
      .idx_x  (idx_x),
      .idx_z  (idx_z),
      .cfg    (cfg_ff),
      .flags  (flg_ff[DEPTH-2]),
      .result (result)
   );

   assign rsp_min_cell_x = result.min_x;
   assign rsp_max_cell_x = result.max_x;
   assign rsp_min_cell_z = result.min_z;
   assign rsp_max_cell_z = result.max_z;
   assign rsp_z_outer    = result.flags.z_outer;
   assign rsp_reverse_x  = result.flags.reverse_x;
   assign rsp_reverse_z  = result.flags.reverse_z;

   // checks
   `FGW_ASSERT_NOW(a_full_output_stalls, rsp_valid && !rsp_ready, !req_ready,
      "input taken while the output item is held")
   `FGW_ASSERT_NEXT(a_stall_freezes_valids, !pipe_en, $stable(vld_ff),
      "valid bits moved during a stall")
   `FGW_ASSERT_NOW(a_window_x_ordered, rsp_valid,
      (rsp_min_cell_x <= rsp_max_cell_x) &&
      (rsp_max_cell_x <= fgw_pkg::cell_limit(cfg_ff.cells_x)),
      "X window out of order or beyond the grid")
   `FGW_ASSERT_NOW(a_window_z_ordered, rsp_valid,
      (rsp_min_cell_z <= rsp_max_cell_z) &&
      (rsp_max_cell_z <= fgw_pkg::cell_limit(cfg_ff.cells_z)),
      "Z window out of order or beyond the grid")
   `FGW_ASSERT_NEXT(a_cells_x_written, csr_write && (reg_idx == fgw_pkg::REG_CELLS_X),
      cfg_ff.cells_x == $past(pwdata[fgw_pkg::CELL_W-1:0]),
      "column count write lost")

endmodule

`default_nettype wire
